/* rtl/core/pjst_pkg.sv */
// ============================================================================
// pjst_pkg: shared types and constants of the priority job scheduler
// Field widths, the stored job entry, cell control and controller states.
// ============================================================================
`timescale 1ns / 1ps

package pjst_pkg;

    localparam int SVC_W  = 16;  // service time
    localparam int PRIO_W = 8;   // priority
    localparam int NUM_W  = 5;   // load-order job number
    localparam int TIME_W = 20;  // finish and waiting time
    localparam int SUM_W  = 24;  // running sums and totals

    typedef struct packed {
        logic [NUM_W-1:0]  number;
        logic [SVC_W-1:0]  service;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    // Per-cycle command to every cell of the chain.
    typedef struct packed {
        logic ins;  // place the incoming job in sorted position
        logic pop;  // shift the chain one place toward the head
    } cell_ctrl_t;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } state_t;

endpackage

/* rtl/core/priority_job_schedule_times_unit.sv */
// ============================================================================
// priority_job_schedule_times_unit: nonpreemptive priority schedule times
// Loading takes one job request per cycle; each is inserted into
// a chain of MAX_JOBS cells kept in stable ascending priority order.
// After the request marked last, the batch is emitted one result per cycle
// while m_ready is high, from the cycle after, as the chain moves to its head.
// Input is not taken while results are emitted. Reset (synchronous, active
// low) empties the chain, clears the drop flag and restarts job numbering.
// ============================================================================
`timescale 1ns / 1ps

module priority_job_schedule_times_unit #(
    parameter int MAX_JOBS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [pjst_pkg::SVC_W-1:0]     s_service_time,
    input  logic [pjst_pkg::PRIO_W-1:0]    s_job_priority,
    input  logic                           s_last_job,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [pjst_pkg::NUM_W-1:0]     m_job_number,
    output logic [pjst_pkg::SVC_W-1:0]     m_job_service,
    output logic [pjst_pkg::TIME_W-1:0]    m_finish_time,
    output logic [pjst_pkg::TIME_W-1:0]    m_waiting_time,
    output logic [pjst_pkg::SUM_W-1:0]     m_total_turnaround,
    output logic [pjst_pkg::SUM_W-1:0]     m_total_waiting,
    output logic                           m_overflow,
    output logic                           m_end_of_batch
);
    import pjst_pkg::*;

    localparam int CNT_W = $clog2(MAX_JOBS + 1);

    // controller state
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;       // jobs held in the chain
    logic             drop_reg, drop_next;     // a job of this batch was dropped
    logic [NUM_W-1:0] num_reg, num_next;       // last load-order number issued
    // emission sums: wait_reg is the finish time of the previous job
    logic [SUM_W-1:0] wait_reg, wait_next;
    logic [SUM_W-1:0] tat_reg, tat_next;
    logic [SUM_W-1:0] wt_reg, wt_next;

    cell_ctrl_t       ctrl;
    entry_t           new_entry;
    entry_t           cell_q [MAX_JOBS];
    logic             cell_gt [MAX_JOBS];
    logic             in_acc;
    logic             out_acc;
    logic             full;
    logic             last_out;
    logic [SUM_W-1:0] finish;

    assign full      = cnt_reg == CNT_W'(MAX_JOBS);
    assign in_acc    = s_valid && s_ready;
    assign out_acc   = m_valid && m_ready;
    assign last_out  = cnt_reg == CNT_W'(1);
    assign finish    = wait_reg + SUM_W'(cell_q[0].service);

    assign new_entry.number  = num_reg + NUM_W'(1);
    assign new_entry.service = s_service_time;
    assign new_entry.prio    = s_job_priority;

    // ------------------------------------------------------------------
    // Cell chain: cell 0 is the head and always holds the next result.
    // ------------------------------------------------------------------
    for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
        entry_t left_e;
        entry_t right_e;
        logic   left_g;

        if (i == 0) begin : g_head
            assign left_e = new_entry;
            assign left_g = 1'b0;
        end else begin : g_body
            assign left_e = cell_q[i-1];
            assign left_g = cell_gt[i-1];
        end

        if (i == MAX_JOBS - 1) begin : g_tail
            assign right_e = cell_q[i];
        end else begin : g_mid
            assign right_e = cell_q[i+1];
        end

        pjst_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .new_entry   (new_entry),
            .left_entry  (left_e),
            .right_entry (right_e),
            .left_gt     (left_g),
            .count       (cnt_reg),
            .entry       (cell_q[i]),
            .gt          (cell_gt[i])
        );
    end

    // ------------------------------------------------------------------
    // Result fields come straight from the head cell and the sums.
    // ------------------------------------------------------------------
    assign m_job_number       = cell_q[0].number;
    assign m_job_service      = cell_q[0].service;
    assign m_finish_time      = finish[TIME_W-1:0];
    assign m_waiting_time     = wait_reg[TIME_W-1:0];
    assign m_total_turnaround = last_out ? (tat_reg + finish) : '0;
    assign m_total_waiting    = last_out ? (wt_reg + wait_reg) : '0;
    assign m_overflow         = drop_reg;
    assign m_end_of_batch     = last_out;

    // ------------------------------------------------------------------
    // Controller: load requests, then walk the chain out.
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        drop_next  = drop_reg;
        num_next   = num_reg;
        wait_next  = wait_reg;
        tat_next   = tat_reg;
        wt_next    = wt_reg;
        ctrl       = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;

        case (state_reg)
            ST_LOAD: begin
                s_ready = 1'b1;
                if (in_acc) begin
                    // numbering advances even for a dropped job
                    num_next = num_reg + NUM_W'(1);
                    if (full) begin
                        drop_next = 1'b1;
                    end else begin
                        ctrl.ins = 1'b1;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    if (s_last_job) begin
                        wait_next  = '0;
                        tat_next   = '0;
                        wt_next    = '0;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                m_valid = 1'b1;
                if (out_acc) begin
                    ctrl.pop  = 1'b1;
                    wait_next = finish;
                    tat_next  = tat_reg + finish;
                    wt_next   = wt_reg + wait_reg;
                    cnt_next  = cnt_reg - CNT_W'(1);
                    if (last_out) begin
                        // batch done: drop the flag and restart numbering
                        drop_next  = 1'b0;
                        num_next   = '0;
                        state_next = ST_LOAD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            drop_reg  <= 1'b0;
            num_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            drop_reg  <= drop_next;
            num_reg   <= num_next;
        end
    end

    always_ff @(posedge aclk) begin
        wait_reg <= wait_next;
        tat_reg  <= tat_next;
        wt_reg   <= wt_next;
    end

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("load and emit active together");

    a_emit_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (cnt_reg != '0))
        else $error("emitting from an empty chain");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_JOBS))
        else $error("job count beyond capacity");

    a_last_starts_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && s_last_job) |=> m_valid)
        else $error("last request did not start emission");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_acc && m_end_of_batch) |=> (cnt_reg == '0 && !drop_reg))
        else $error("batch state not cleared after final result");
`endif

endmodule

/* rtl/core/pjst_cell.sv */
// ============================================================================
// pjst_cell: one slot of the sorted job chain
// Holds one job; takes the new job, its left neighbor's job, or its right
// neighbor's job, as the chain inserts or shifts toward the head.
// ============================================================================
`timescale 1ns / 1ps

module pjst_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 5
) (
    input  logic                aclk,
    input  pjst_pkg::cell_ctrl_t ctrl,
    input  pjst_pkg::entry_t    new_entry,
    input  pjst_pkg::entry_t    left_entry,
    input  pjst_pkg::entry_t    right_entry,
    input  logic                left_gt,
    input  logic [CNT_W-1:0]    count,
    output pjst_pkg::entry_t    entry,
    output logic                gt
);
    import pjst_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   occ;
    logic   left_occ;

    assign occ      = count > CNT_W'(INDEX);
    assign left_occ = count >= CNT_W'(INDEX);
    assign gt       = occ && (entry_reg.prio > new_entry.prio);
    assign entry    = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.pop) begin
            entry_next = right_entry;
        end else if (ctrl.ins) begin
            // stored jobs of higher priority value move one place down
            if (left_gt) begin
                entry_next = left_entry;
            end else if ((gt || !occ) && left_occ) begin
                entry_next = new_entry;
            end
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

/* dv/pjst_schedule_checker.sv */
// ============================================================================
// pjst_schedule_checker: scoreboard for the priority job scheduler
// Watches both channels, keeps its own sorted job store and schedule sums,
// and compares every emitted result with the oldest predicted one.
// ============================================================================
`timescale 1ns / 1ps

module pjst_schedule_checker #(
    parameter int MAX_JOBS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [pjst_pkg::SVC_W-1:0]     s_service_time,
    input  logic [pjst_pkg::PRIO_W-1:0]    s_job_priority,
    input  logic                           s_last_job,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [pjst_pkg::NUM_W-1:0]     m_job_number,
    input  logic [pjst_pkg::SVC_W-1:0]     m_job_service,
    input  logic [pjst_pkg::TIME_W-1:0]    m_finish_time,
    input  logic [pjst_pkg::TIME_W-1:0]    m_waiting_time,
    input  logic [pjst_pkg::SUM_W-1:0]     m_total_turnaround,
    input  logic [pjst_pkg::SUM_W-1:0]     m_total_waiting,
    input  logic                           m_overflow,
    input  logic                           m_end_of_batch,
    output int                             err_count,
    output int                             open_results
);

    import pjst_pkg::*;

    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        logic [NUM_W-1:0]  number;
        logic [SVC_W-1:0]  service;
        logic [TIME_W-1:0] finish;
        logic [TIME_W-1:0] waiting;
        logic [SUM_W-1:0]  tot_tat;
        logic [SUM_W-1:0]  tot_wait;
        logic              overflow;
        logic              batch_end;
    } sched_line_t;

    entry_t        job_store [MAX_JOBS];
    int unsigned   stored_jobs;
    int unsigned   load_number;
    bit            jobs_dropped;
    sched_line_t   schedule_q[$];
    sched_line_t   want;
    sched_line_t   got;
    string         diffs;

    task automatic note_failure(input string msg);
        err_count++;
        if (err_count <= MAX_SHOWN) begin
            $display("[%0t] %s", $realtime, msg);
        end
    endtask

    // Stable sorted insert: the new job goes behind every stored job of
    // equal priority. Its number is used up even when the store is full.
    function automatic void load_job(input logic [SVC_W-1:0] svc,
                                     input logic [PRIO_W-1:0] prio);
        int unsigned pos;
        load_number++;
        if (stored_jobs >= MAX_JOBS) begin
            jobs_dropped = 1'b1;
            return;
        end
        pos = stored_jobs;
        while (pos > 0 && job_store[pos-1].prio > prio) begin
            pos--;
        end
        for (int unsigned k = stored_jobs; k > pos; k--) begin
            job_store[k] = job_store[k-1];
        end
        job_store[pos].number  = load_number[NUM_W-1:0];
        job_store[pos].service = svc;
        job_store[pos].prio    = prio;
        stored_jobs++;
    endfunction

    // Walk the store in schedule order and queue one result per job.
    function automatic void emit_schedule();
        logic [63:0] finish_sum;
        logic [63:0] tat_sum;
        logic [63:0] wait_sum;
        sched_line_t line;
        finish_sum = '0;
        tat_sum    = '0;
        wait_sum   = '0;
        for (int unsigned i = 0; i < stored_jobs; i++) begin
            line.waiting   = finish_sum[TIME_W-1:0];
            wait_sum      += finish_sum;
            finish_sum    += job_store[i].service;
            tat_sum       += finish_sum;
            line.number    = job_store[i].number;
            line.service   = job_store[i].service;
            line.finish    = finish_sum[TIME_W-1:0];
            line.tot_tat   = '0;
            line.tot_wait  = '0;
            line.overflow  = jobs_dropped;
            line.batch_end = 1'b0;
            if (i == stored_jobs - 1) begin
                line.tot_tat   = tat_sum[SUM_W-1:0];
                line.tot_wait  = wait_sum[SUM_W-1:0];
                line.batch_end = 1'b1;
            end
            schedule_q.push_back(line);
        end
        stored_jobs  = 0;
        load_number  = 0;
        jobs_dropped = 1'b0;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            stored_jobs  = 0;
            load_number  = 0;
            jobs_dropped = 1'b0;
            schedule_q.delete();
        end else begin
            // Results belong to an earlier batch than any request taken now.
            if (m_valid && m_ready) begin
                got = '{m_job_number, m_job_service, m_finish_time, m_waiting_time,
                        m_total_turnaround, m_total_waiting, m_overflow,
                        m_end_of_batch};
                if (schedule_q.size() == 0) begin
                    note_failure($sformatf("unexpected result: %p", got));
                end else begin
                    want  = schedule_q.pop_front();
                    diffs = "";
                    if (got.number !== want.number)       diffs = {diffs, " job_number"};
                    if (got.service !== want.service)     diffs = {diffs, " job_service"};
                    if (got.finish !== want.finish)       diffs = {diffs, " finish_time"};
                    if (got.waiting !== want.waiting)     diffs = {diffs, " waiting_time"};
                    if (got.tot_tat !== want.tot_tat)     diffs = {diffs, " total_turnaround"};
                    if (got.tot_wait !== want.tot_wait)   diffs = {diffs, " total_waiting"};
                    if (got.overflow !== want.overflow)   diffs = {diffs, " overflow"};
                    if (got.batch_end !== want.batch_end) diffs = {diffs, " end_of_batch"};
                    if (diffs != "") begin
                        note_failure($sformatf("mismatch in%s\n  expected %p\n  actual   %p",
                                               diffs, want, got));
                    end
                end
            end
            if (s_valid && s_ready) begin
                load_job(s_service_time, s_job_priority);
                if (s_last_job) begin
                    emit_schedule();
                end
            end
        end
        open_results = schedule_q.size();
    end

endmodule

/* dv/tb_priority_job_schedule_times_unit.sv */
// ============================================================================
// tb_priority_job_schedule_times_unit: batch scheduling regression
// Loads batches of jobs (single job, full store, overflow with a dropped
// final request, priority ties, extreme service times, then random batches)
// under changing sender and receiver idling; the checker scores results.
// ============================================================================
`timescale 1ns / 1ps

module tb_priority_job_schedule_times_unit;

    import pjst_pkg::*;

    localparam int MAX_JOBS     = 16;
    localparam int RANDOM_JOBS  = 230;
    localparam int QUIET_LIMIT  = 2000;  // cycles with no handshake at all
    localparam int DRAIN_CYCLES = 40;

    // How priorities of a random batch are drawn.
    typedef enum int {
        PRIO_SPREAD,  // full range
        PRIO_FEW,     // a handful of values, many ties
        PRIO_SAME     // one value for the whole batch
    } prio_mode_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [SVC_W-1:0]    s_service_time;
    logic [PRIO_W-1:0]   s_job_priority;
    logic                s_last_job;
    logic                m_valid;
    logic                m_ready;
    logic [NUM_W-1:0]    m_job_number;
    logic [SVC_W-1:0]    m_job_service;
    logic [TIME_W-1:0]   m_finish_time;
    logic [TIME_W-1:0]   m_waiting_time;
    logic [SUM_W-1:0]    m_total_turnaround;
    logic [SUM_W-1:0]    m_total_waiting;
    logic                m_overflow;
    logic                m_end_of_batch;

    int err_count;
    int open_results;
    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;

    priority_job_schedule_times_unit #(
        .MAX_JOBS(MAX_JOBS)
    ) DUT (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_service_time     (s_service_time),
        .s_job_priority     (s_job_priority),
        .s_last_job         (s_last_job),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_job_number       (m_job_number),
        .m_job_service      (m_job_service),
        .m_finish_time      (m_finish_time),
        .m_waiting_time     (m_waiting_time),
        .m_total_turnaround (m_total_turnaround),
        .m_total_waiting    (m_total_waiting),
        .m_overflow         (m_overflow),
        .m_end_of_batch     (m_end_of_batch)
    );

    pjst_schedule_checker #(
        .MAX_JOBS(MAX_JOBS)
    ) u_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_service_time     (s_service_time),
        .s_job_priority     (s_job_priority),
        .s_last_job         (s_last_job),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_job_number       (m_job_number),
        .m_job_service      (m_job_service),
        .m_finish_time      (m_finish_time),
        .m_waiting_time     (m_waiting_time),
        .m_total_turnaround (m_total_turnaround),
        .m_total_waiting    (m_total_waiting),
        .m_overflow         (m_overflow),
        .m_end_of_batch     (m_end_of_batch),
        .err_count          (err_count),
        .open_results       (open_results)
    );

    // 20 ns clock.
    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // Stall the result channel at random; the rate follows the current phase.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: end the run when neither channel moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Present one request and hold it until accepted. Called and returning
    // at a falling edge; valid only drops for a sender gap.
    task automatic send_job(input logic [SVC_W-1:0] svc,
                            input logic [PRIO_W-1:0] prio,
                            input logic final_job);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_service_time <= svc;
        s_job_priority <= prio;
        s_last_job     <= final_job;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Hold the sender until every predicted result has been taken.
    task automatic drain_schedule();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (open_results != 0) begin
            @(negedge aclk);
        end
    endtask

    // Pick the idling mix for a phase: none, sender, receiver, both.
    task automatic set_phase(input int phase);
        case (phase % 4)
            0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
            1: begin send_idle_pct <= 58; recv_stall_pct <= 0;  end
            2: begin send_idle_pct <= 0;  recv_stall_pct <= 58; end
            default: begin send_idle_pct <= 35; recv_stall_pct <= 35; end
        endcase
    endtask

    // One random batch: mostly within capacity, now and then past it.
    task automatic random_batch(output int jobs_sent);
        int               batch_size;
        prio_mode_t       mode;
        logic [PRIO_W-1:0] same_prio;
        logic [PRIO_W-1:0] prio;
        logic [SVC_W-1:0]  svc;
        batch_size = ($urandom_range(7) == 0) ? $urandom_range(MAX_JOBS + 4, MAX_JOBS + 1)
                                              : $urandom_range(MAX_JOBS, 1);
        mode       = prio_mode_t'($urandom_range(2));
        same_prio  = PRIO_W'($urandom_range(255));
        for (int i = 0; i < batch_size; i++) begin
            case (mode)
                PRIO_SPREAD: prio = PRIO_W'($urandom_range(255));
                PRIO_FEW:    prio = PRIO_W'($urandom_range(3));
                default:     prio = same_prio;
            endcase
            svc = ($urandom_range(3) == 0) ? SVC_W'($urandom_range(15)) : SVC_W'($urandom());
            send_job(svc, prio, i == batch_size - 1);
        end
        jobs_sent = batch_size;
    endtask

    initial begin
        int jobs_done;
        int batch_jobs;
        int batch_idx;

        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_service_time = '0;
        s_job_priority = '0;
        s_last_job     = 1'b0;
        m_ready        = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        quiet_cycles   = 0;

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Single-job batch: longest service, top priority.
        send_job(16'hFFFF, 8'h00, 1'b1);

        // Full store plus one: longest services everywhere, priorities at
        // both ends and in the middle, with ties; the final request is dropped
        // yet still releases the batch, flagged as overflow.
        for (int i = 0; i <= MAX_JOBS; i++) begin
            send_job(16'hFFFF, (i % 3 == 0) ? 8'hFF : (i % 3 == 1) ? 8'h00 : 8'h55,
                     i == MAX_JOBS);
        end

        // Zero service and a late top-priority job overtaking a tie.
        send_job(16'h0000, 8'hFF, 1'b0);
        send_job(16'hFFFF, 8'hFF, 1'b0);
        send_job(16'h0001, 8'h00, 1'b1);
        drain_schedule();

        // Random batches, idling mix changing every few batches.
        jobs_done = 0;
        batch_idx = 0;
        while (jobs_done < RANDOM_JOBS) begin
            if (batch_idx % 3 == 0) begin
                set_phase(batch_idx / 3);
            end
            random_batch(batch_jobs);
            jobs_done += batch_jobs;
            batch_idx++;
            if (batch_idx % 5 == 0) begin
                drain_schedule();
            end
        end

        // Drop valid, let the last batch drain, then give the verdict.
        s_valid <= 1'b0;
        recv_stall_pct <= 0;
        while (open_results != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (err_count == 0 && open_results == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* priority_job_schedule_times_unit.f */
rtl/core/pjst_pkg.sv
rtl/core/pjst_cell.sv
rtl/core/priority_job_schedule_times_unit.sv
dv/pjst_schedule_checker.sv
dv/tb_priority_job_schedule_times_unit.sv
